// File: design/rcpg_pkg.sv
// shared types and constants for the rx cell power / gain ranging loop
package rcpg_pkg;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    localparam logic signed [11:0] START_POWER = -12'sd500;
    localparam logic signed [8:0]  GAIN_STEP   = 9'sd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_LEVEL  = 3'd0,
        REG_TOLERANCE     = 3'd1,
        REG_POWER_FLOOR   = 3'd2,
        REG_POWER_CEILING = 3'd3,
        REG_GAIN_FLOOR    = 3'd4,
        REG_GAIN_CEILING  = 3'd5,
        REG_GAIN_START    = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_IN_WINDOW = 3'd1,
        ST_DONE      = 3'd2,
        ST_POWER     = 3'd3,
        ST_GAIN      = 3'd4,
        ST_TOO_HIGH  = 3'd5,
        ST_TOO_LOW   = 3'd6
    } status_t;

    typedef struct packed {
        logic signed [11:0] target_level;
        logic        [8:0]  tolerance;
        logic signed [11:0] power_floor;
        logic signed [11:0] power_ceiling;
        logic        [6:0]  gain_floor;
        logic        [6:0]  gain_ceiling;
        logic        [6:0]  gain_start;
    } cfg_t;

    typedef struct packed {
        logic signed [11:0] power;
        logic        [6:0]  gain;
    } entry_t;

    typedef struct packed {
        status_t status;
        entry_t  entry;
        logic    done;
    } upd_t;

endpackage

// File: design/rcpg_cfg_regs.sv
// configuration register file with write decode
module rcpg_cfg_regs
    import rcpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TARGET_LEVEL:  cfg_next.target_level  = cfg_wdata;
                REG_TOLERANCE:     cfg_next.tolerance     = cfg_wdata[8:0];
                REG_POWER_FLOOR:   cfg_next.power_floor   = cfg_wdata;
                REG_POWER_CEILING: cfg_next.power_ceiling = cfg_wdata;
                REG_GAIN_FLOOR:    cfg_next.gain_floor    = cfg_wdata[6:0];
                REG_GAIN_CEILING:  cfg_next.gain_ceiling  = cfg_wdata[6:0];
                REG_GAIN_START:    cfg_next.gain_start    = cfg_wdata[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level  <= -12'sd600;
            cfg_reg.tolerance     <= 9'd10;
            cfg_reg.power_floor   <= -12'sd900;
            cfg_reg.power_ceiling <= -12'sd300;
            cfg_reg.gain_floor    <= 7'd14;
            cfg_reg.gain_ceiling  <= 7'd108;
            cfg_reg.gain_start    <= 7'd60;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/rcpg_chan_mem.sv
// per-channel power and gain store, one write port and one registered read port
module rcpg_chan_mem
    import rcpg_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem_reg [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/rcpg_update.sv
// one-pass channel update: start load, window check, power step and clamp, gain step
module rcpg_update
    import rcpg_pkg::*;
(
    input  cfg_t               cfg,
    input  logic               op,
    input  logic signed [11:0] rssi,
    input  entry_t             cur,
    input  logic               cur_done,
    output upd_t               upd
);

    logic signed [13:0] tgt_x;
    logic signed [13:0] rssi_x;
    logic signed [13:0] win_lo;
    logic signed [13:0] win_hi;
    logic signed [13:0] err;
    logic signed [15:0] pw_adj;
    logic signed [15:0] floor_x;
    logic signed [15:0] ceil_x;
    logic signed [15:0] pw_hi_lim;
    logic signed [15:0] pw_lim;
    logic signed [12:0] lim_sum;
    logic signed [11:0] mid;
    logic signed [8:0]  gi_x;
    logic signed [8:0]  gi_step;
    logic signed [8:0]  gfloor_x;
    logic signed [8:0]  gceil_x;
    logic signed [8:0]  gi_hi_lim;
    logic signed [8:0]  gi_lim;
    logic               above;
    logic               in_win;
    logic               pw_at_lim;
    logic               gi_at_lim;

    always_comb
    begin
        tgt_x   = {{2{cfg.target_level[11]}}, cfg.target_level};
        rssi_x  = {{2{rssi[11]}}, rssi};
        win_lo  = tgt_x - {5'b0, cfg.tolerance};
        win_hi  = tgt_x + {5'b0, cfg.tolerance};
        in_win  = (rssi_x >= win_lo) && (rssi_x <= win_hi);
        above   = rssi_x > win_hi;

        // power moves against the error, ceiling first then floor
        err       = rssi_x - tgt_x;
        pw_adj    = {{4{cur.power[11]}}, cur.power} - {{2{err[13]}}, err};
        floor_x   = {{4{cfg.power_floor[11]}}, cfg.power_floor};
        ceil_x    = {{4{cfg.power_ceiling[11]}}, cfg.power_ceiling};
        pw_hi_lim = (pw_adj > ceil_x) ? ceil_x : pw_adj;
        pw_lim    = (pw_hi_lim < floor_x) ? floor_x : pw_hi_lim;

        // midpoint rounds toward minus infinity
        lim_sum = {cfg.power_floor[11], cfg.power_floor}
                + {cfg.power_ceiling[11], cfg.power_ceiling};
        mid     = lim_sum[12:1];

        gi_x      = {2'b00, cur.gain};
        gi_step   = above ? (gi_x - GAIN_STEP) : (gi_x + GAIN_STEP);
        gfloor_x  = {2'b00, cfg.gain_floor};
        gceil_x   = {2'b00, cfg.gain_ceiling};
        gi_hi_lim = (gi_step > gceil_x) ? gceil_x : gi_step;
        gi_lim    = (gi_hi_lim < gfloor_x) ? gfloor_x : gi_hi_lim;

        pw_at_lim = above ? (cur.power == cfg.power_floor) : (cur.power == cfg.power_ceiling);
        gi_at_lim = above ? (cur.gain == cfg.gain_floor) : (cur.gain == cfg.gain_ceiling);

        upd.status = ST_DONE;
        upd.entry  = cur;
        upd.done   = cur_done;

        if (op == OP_START)
        begin
            upd.status      = ST_STARTED;
            upd.entry.power = START_POWER;
            upd.entry.gain  = cfg.gain_start;
            upd.done        = 1'b0;
        end
        else if (cur_done)
        begin
            upd.status = ST_DONE;
        end
        else if (in_win)
        begin
            upd.status = ST_IN_WINDOW;
            upd.done   = 1'b1;
        end
        else if (!pw_at_lim)
        begin
            upd.status      = ST_POWER;
            upd.entry.power = pw_lim[11:0];
        end
        else if (gi_at_lim)
        begin
            upd.status = above ? ST_TOO_HIGH : ST_TOO_LOW;
        end
        else
        begin
            upd.status      = ST_GAIN;
            upd.entry.power = mid;
            upd.entry.gain  = gi_lim[6:0];
        end
    end

endmodule

// File: design/rx_cell_power_gain_ranging_loop_unit.sv
// top level of the rx cell power / gain ranging loop
//
// Input channel: in_valid / in_stall with op, channel and rssi. An op of start
// loads the addressed channel with -50 dBm and the configured start gain and
// clears its done flag; a measure op brings the rssi seen on that channel and
// steps its power or gain toward the target window.
// Output channel: out_valid / out_stall, one result beat per input beat, in
// order, carrying the channel, a status code and the values to apply next.
// The input register captures the beat and reads the channel store; the
// update logic then loads the result register. While the receiver does not
// stall a new beat is taken every cycle; back-to-back beats on the same channel
// see each other's update through a bypass around the store's registered read.
// When the receiver stalls, the finished result holds in the result register
// and one more beat waits in the input register; after that in_stall rises.
// Reset clears the pipeline, every done flag and the configuration registers
// to their defaults. Power and gain of a channel hold no value until a start
// beat writes them. Configuration is written through cfg_wr_en / cfg_index /
// cfg_wdata only while the block is idle, a rule for the user that the block does not enforce.
module rx_cell_power_gain_ranging_loop_unit
    import rcpg_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [3:0]            channel,
    input  logic signed [11:0]    rssi,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            channel_out,
    output logic [2:0]            status,
    output logic signed [11:0]    cell_power,
    output logic [6:0]            gain_index,
    output logic                  converged
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // channel number to store entry, wrapping at CHANNELS
    function automatic logic [IDX_W-1:0] entry_of(input logic [3:0] ch);
        logic [IDX_W-1:0] e;
        e = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (ch == 4'(i))
            begin
                e = IDX_W'(i % CHANNELS);
            end
        end
        return e;
    endfunction

    cfg_t               cfg;
    entry_t             rd_data;
    entry_t             cur;
    upd_t               upd;
    logic [IDX_W-1:0]   in_idx;
    logic               accept;
    logic               advance;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_op_reg;
    logic [3:0]         s1_ch_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic signed [11:0] s1_rssi_reg;
    logic               byp_hit_reg;
    entry_t             byp_data_reg;

    logic [CHANNELS-1:0] done_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [3:0]         out_ch_reg;
    status_t            out_status_reg;
    entry_t             out_entry_reg;
    logic               out_done_reg;

    rcpg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign in_idx   = entry_of(channel);
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    rcpg_chan_mem #(
        .DEPTH (CHANNELS),
        .IDX_W (IDX_W)
    ) u_chan_mem (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_idx_reg),
        .wr_data (upd.entry),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (rd_data)
    );

    // a write landing on the same edge as the read wins over the stale read
    assign cur = byp_hit_reg ? byp_data_reg : rd_data;

    rcpg_update u_update (
        .cfg      (cfg),
        .op       (s1_op_reg),
        .rssi     (s1_rssi_reg),
        .cur      (cur),
        .cur_done (done_reg[s1_idx_reg]),
        .upd      (upd)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                done_reg[s1_idx_reg] <= upd.done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= op;
            s1_ch_reg    <= channel;
            s1_idx_reg   <= in_idx;
            s1_rssi_reg  <= rssi;
            byp_hit_reg  <= advance && (s1_idx_reg == in_idx);
            byp_data_reg <= upd.entry;
        end
        if (advance)
        begin
            out_ch_reg     <= s1_ch_reg;
            out_status_reg <= upd.status;
            out_entry_reg  <= upd.entry;
            out_done_reg   <= upd.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = out_ch_reg;
    assign status      = out_status_reg;
    assign cell_power  = out_entry_reg.power;
    assign gain_index  = out_entry_reg.gain;
    assign converged   = out_done_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could drain");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("result lost after leaving the input register");

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_STARTED) |-> (!converged && cell_power == START_POWER))
        else $error("start result does not show a fresh channel");

    a_error_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_TOO_HIGH || status == ST_TOO_LOW)) |-> !converged)
        else $error("gain limit error reported on a converged channel");

    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_DONE || status == ST_IN_WINDOW)) |-> converged)
        else $error("window or done result without converged flag");

endmodule
